### src/v2a_pkg.sv
// ----------------------------------------------------------------------------
// v2a_pkg: shared types and constants for the 2D vector ALU
// Word format, mode and status codes, and the records passed along the cells.
// ----------------------------------------------------------------------------
`default_nettype none
package v2a_pkg;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int FACT_BITS = 16;
  localparam int RAD_BITS  = 2 * WORD_BITS;
  localparam int REM_BITS  = WORD_BITS + 3;
  localparam int QUO_BITS  = FRAC_BITS + 1;
  localparam int DIV_CELLS = FRAC_BITS + 1;

  typedef enum logic [2:0] {
    MODE_ADD   = 3'd0,
    MODE_SUB   = 3'd1,
    MODE_SCALE = 3'd2,
    MODE_LEN   = 3'd3,
    MODE_NORM  = 3'd4
  } mode_e;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_SAT  = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  // per item record carried alongside the length and divide cells
  typedef struct packed {
    logic [2:0]           mode;
    logic                 neg_x;
    logic                 neg_y;
    logic [WORD_BITS-1:0] abs_x;
    logic [WORD_BITS-1:0] abs_y;
    logic [WORD_BITS-1:0] rx;
    logic [WORD_BITS-1:0] ry;
    logic                 sat;
  } item_t;

  // one lane of the restoring divider
  typedef struct packed {
    logic [WORD_BITS-1:0] rem;
    logic                 lsb;
    logic [QUO_BITS-1:0]  quo;
  } div_lane_t;

endpackage
`default_nettype wire

### src/v2a_front.sv
// ----------------------------------------------------------------------------
// v2a_front: entry stages
// Does add, subtract and scale with saturation, then squares and sums the
// magnitudes of the first vector to feed the square root cells.
// ----------------------------------------------------------------------------
`default_nettype none
module v2a_front (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic                               valid_i,
  input  wire logic [2:0]                         mode_i,
  input  wire logic signed [v2a_pkg::WORD_BITS-1:0] first_x_i,
  input  wire logic signed [v2a_pkg::WORD_BITS-1:0] first_y_i,
  input  wire logic signed [v2a_pkg::WORD_BITS-1:0] second_x_i,
  input  wire logic signed [v2a_pkg::WORD_BITS-1:0] second_y_i,
  input  wire logic signed [v2a_pkg::FACT_BITS-1:0] factor_i,
  output logic                                    valid_o,
  output v2a_pkg::item_t                          item_o,
  output logic [v2a_pkg::RAD_BITS-1:0]            rad_o
);
  import v2a_pkg::*;

  localparam int PB = WORD_BITS + FACT_BITS;

  logic signed [WORD_BITS:0]   sum_x, sum_y, dif_x, dif_y;
  logic signed [PB-1:0]        prd_x, prd_y;
  logic [WORD_BITS-1:0]        rx_d, ry_d;
  logic                        sat_d;
  item_t                       a_d, a_q, b_q, c_q;
  logic                        va_q, vb_q, vc_q;
  logic [RAD_BITS-1:0]         sqx_q, sqy_q, rad_q;

  function automatic logic [WORD_BITS:0] clamp_add(input logic signed [WORD_BITS:0] v);
    logic [WORD_BITS:0] r;
    r = {1'b0, v[WORD_BITS-1:0]};
    if (v[WORD_BITS] != v[WORD_BITS-1]) begin
      r = {1'b1, v[WORD_BITS], {(WORD_BITS-1){~v[WORD_BITS]}}};
    end
    return r;
  endfunction

  function automatic logic [WORD_BITS:0] clamp_mul(input logic signed [PB-1:0] v);
    logic [WORD_BITS:0] r;
    r = {1'b0, v[WORD_BITS-1:0]};
    if (!((&v[PB-1:WORD_BITS-1]) || !(|v[PB-1:WORD_BITS-1]))) begin
      r = {1'b1, v[PB-1], {(WORD_BITS-1){~v[PB-1]}}};
    end
    return r;
  endfunction

  // arithmetic modes with per component saturation
  always_comb begin
    logic [WORD_BITS:0] cx, cy;
    sum_x = {first_x_i[WORD_BITS-1], first_x_i} + {second_x_i[WORD_BITS-1], second_x_i};
    sum_y = {first_y_i[WORD_BITS-1], first_y_i} + {second_y_i[WORD_BITS-1], second_y_i};
    dif_x = {first_x_i[WORD_BITS-1], first_x_i} - {second_x_i[WORD_BITS-1], second_x_i};
    dif_y = {first_y_i[WORD_BITS-1], first_y_i} - {second_y_i[WORD_BITS-1], second_y_i};
    prd_x = PB'(first_x_i) * PB'(factor_i);
    prd_y = PB'(first_y_i) * PB'(factor_i);
    cx = '0;
    cy = '0;
    unique case (mode_i)
      MODE_ADD: begin
        cx = clamp_add(sum_x);
        cy = clamp_add(sum_y);
      end
      MODE_SUB: begin
        cx = clamp_add(dif_x);
        cy = clamp_add(dif_y);
      end
      MODE_SCALE: begin
        cx = clamp_mul(prd_x);
        cy = clamp_mul(prd_y);
      end
      default: begin
        cx = '0;
        cy = '0;
      end
    endcase
    rx_d  = cx[WORD_BITS-1:0];
    ry_d  = cy[WORD_BITS-1:0];
    sat_d = cx[WORD_BITS] | cy[WORD_BITS];
    a_d.mode  = mode_i;
    a_d.neg_x = first_x_i[WORD_BITS-1];
    a_d.neg_y = first_y_i[WORD_BITS-1];
    a_d.abs_x = first_x_i[WORD_BITS-1] ? WORD_BITS'(-first_x_i) : WORD_BITS'(first_x_i);
    a_d.abs_y = first_y_i[WORD_BITS-1] ? WORD_BITS'(-first_y_i) : WORD_BITS'(first_y_i);
    a_d.rx    = rx_d;
    a_d.ry    = ry_d;
    a_d.sat   = sat_d;
  end

  // valid bits of the three entry stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en_i) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  // advance payload: operands, squares, sum of squares
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= a_d;
      b_q   <= a_q;
      sqx_q <= RAD_BITS'(a_q.abs_x) * RAD_BITS'(a_q.abs_x);
      sqy_q <= RAD_BITS'(a_q.abs_y) * RAD_BITS'(a_q.abs_y);
      c_q   <= b_q;
      rad_q <= sqx_q + sqy_q;
    end
  end

  assign valid_o = vc_q;
  assign item_o  = c_q;
  assign rad_o   = rad_q;

endmodule
`default_nettype wire

### src/v2a_sqrt_cell.sv
// ----------------------------------------------------------------------------
// v2a_sqrt_cell: one digit of the integer square root
// Takes two radicand bits, tries one root bit and hands the partial root on.
// ----------------------------------------------------------------------------
`default_nettype none
module v2a_sqrt_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire v2a_pkg::item_t                item_i,
  input  wire logic [v2a_pkg::RAD_BITS-1:0]  rad_i,
  input  wire logic [v2a_pkg::REM_BITS-1:0]  rem_i,
  input  wire logic [v2a_pkg::WORD_BITS-1:0] root_i,
  output logic                               valid_o,
  output v2a_pkg::item_t                     item_o,
  output logic [v2a_pkg::RAD_BITS-1:0]       rad_o,
  output logic [v2a_pkg::REM_BITS-1:0]       rem_o,
  output logic [v2a_pkg::WORD_BITS-1:0]      root_o
);
  import v2a_pkg::*;

  logic [REM_BITS-1:0]  rem_sh, trial, rem_d;
  logic [WORD_BITS-1:0] root_d;
  logic                 fit;
  item_t                item_q;
  logic [RAD_BITS-1:0]  rad_q;
  logic [REM_BITS-1:0]  rem_q;
  logic [WORD_BITS-1:0] root_q;
  logic                 valid_q;

  // try the next root bit
  always_comb begin
    rem_sh = {rem_i[REM_BITS-3:0], rad_i[RAD_BITS-1 -: 2]};
    trial  = {1'b0, root_i, 2'b01};
    fit    = rem_sh >= trial;
    rem_d  = fit ? rem_sh - trial : rem_sh;
    root_d = {root_i[WORD_BITS-2:0], fit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_i;
      rad_q  <= {rad_i[RAD_BITS-3:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign rad_o   = rad_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;

endmodule
`default_nettype wire

### src/v2a_div_cell.sv
// ----------------------------------------------------------------------------
// v2a_div_cell: one quotient bit of the unit vector divide
// Restoring step for both components against the shared length.
// ----------------------------------------------------------------------------
`default_nettype none
module v2a_div_cell (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          en_i,
  input  wire logic                          valid_i,
  input  wire v2a_pkg::item_t                item_i,
  input  wire logic [v2a_pkg::WORD_BITS-1:0] len_i,
  input  wire v2a_pkg::div_lane_t            lx_i,
  input  wire v2a_pkg::div_lane_t            ly_i,
  output logic                               valid_o,
  output v2a_pkg::item_t                     item_o,
  output logic [v2a_pkg::WORD_BITS-1:0]      len_o,
  output v2a_pkg::div_lane_t                 lx_o,
  output v2a_pkg::div_lane_t                 ly_o
);
  import v2a_pkg::*;

  function automatic div_lane_t step(input div_lane_t l, input logic [WORD_BITS-1:0] d);
    logic [WORD_BITS:0] r2;
    logic               ge;
    div_lane_t          o;
    r2 = {l.rem, l.lsb};
    ge = r2 >= {1'b0, d};
    o.rem = ge ? WORD_BITS'(r2 - {1'b0, d}) : r2[WORD_BITS-1:0];
    o.lsb = 1'b0;
    o.quo = {l.quo[QUO_BITS-2:0], ge};
    return o;
  endfunction

  logic                 valid_q;
  item_t                item_q;
  logic [WORD_BITS-1:0] len_q;
  div_lane_t            lx_q, ly_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // advance one quotient bit per lane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_i;
      len_q  <= len_i;
      lx_q   <= step(lx_i, len_i);
      ly_q   <= step(ly_i, len_i);
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;
  assign len_o   = len_q;
  assign lx_o    = lx_q;
  assign ly_o    = ly_q;

endmodule
`default_nettype wire

### src/vector2d_alu_top.sv
// ----------------------------------------------------------------------------
// vector2d_alu_top: 2D vector ALU in signed fixed point
// Add, subtract, scale, length and normalize of Q16.16 vectors.
// ----------------------------------------------------------------------------
// The block takes one item per clock while no result waits under stall, and
// returns one Q16.16 result per item, in order, after it passes through
// three entry stages, one square root cell per root bit, one divide cell per
// quotient bit and an output register. Every item runs the whole chain,
// whatever its mode. A stall on the output while a result waits holds the
// whole chain, and the input is stalled in that cycle.
`default_nettype none
module vector2d_alu_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic [2:0]                           mode_i,
  input  wire logic signed [v2a_pkg::WORD_BITS-1:0] first_x_i,
  input  wire logic signed [v2a_pkg::WORD_BITS-1:0] first_y_i,
  input  wire logic signed [v2a_pkg::WORD_BITS-1:0] second_x_i,
  input  wire logic signed [v2a_pkg::WORD_BITS-1:0] second_y_i,
  input  wire logic signed [v2a_pkg::FACT_BITS-1:0] factor_i,
  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic signed [v2a_pkg::WORD_BITS-1:0]      result_x_o,
  output logic signed [v2a_pkg::WORD_BITS-1:0]      result_y_o,
  output logic [v2a_pkg::WORD_BITS-1:0]             magnitude_o,
  output logic [1:0]                                status_o
);
  import v2a_pkg::*;

  logic en;
  logic                 sv [WORD_BITS+1];
  item_t                si [WORD_BITS+1];
  logic [RAD_BITS-1:0]  srad [WORD_BITS+1];
  logic [REM_BITS-1:0]  srem [WORD_BITS+1];
  logic [WORD_BITS-1:0] sroot [WORD_BITS+1];
  logic                 dv [DIV_CELLS+1];
  item_t                di [DIV_CELLS+1];
  logic [WORD_BITS-1:0] dlen [DIV_CELLS+1];
  div_lane_t            dx [DIV_CELLS+1];
  div_lane_t            dy [DIV_CELLS+1];
  item_t                fin;
  logic [WORD_BITS-1:0] len;
  logic [WORD_BITS-1:0] rx_d, ry_d, mag_d, rx_q, ry_q, mag_q;
  logic [1:0]           st_d, st_q;
  logic                 ov_q;

  // hold everything while a result waits under stall
  assign en         = !(ov_q && out_stall_i);
  assign in_stall_o = !en;

  v2a_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (en),
    .valid_i    (in_valid_i),
    .mode_i     (mode_i),
    .first_x_i  (first_x_i),
    .first_y_i  (first_y_i),
    .second_x_i (second_x_i),
    .second_y_i (second_y_i),
    .factor_i   (factor_i),
    .valid_o    (sv[0]),
    .item_o     (si[0]),
    .rad_o      (srad[0])
  );
  assign srem[0]  = '0;
  assign sroot[0] = '0;

  // square root chain, one root bit per cell
  for (genvar i = 0; i < WORD_BITS; i++) begin : g_sqrt
    v2a_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sv[i]),
      .item_i  (si[i]),
      .rad_i   (srad[i]),
      .rem_i   (srem[i]),
      .root_i  (sroot[i]),
      .valid_o (sv[i+1]),
      .item_o  (si[i+1]),
      .rad_o   (srad[i+1]),
      .rem_o   (srem[i+1]),
      .root_o  (sroot[i+1])
    );
  end

  // seed the divider: first step compares the whole magnitude
  assign dv[0]       = sv[WORD_BITS];
  assign di[0]       = si[WORD_BITS];
  assign dlen[0]     = sroot[WORD_BITS];
  assign dx[0].rem   = {1'b0, si[WORD_BITS].abs_x[WORD_BITS-1:1]};
  assign dx[0].lsb   = si[WORD_BITS].abs_x[0];
  assign dx[0].quo   = '0;
  assign dy[0].rem   = {1'b0, si[WORD_BITS].abs_y[WORD_BITS-1:1]};
  assign dy[0].lsb   = si[WORD_BITS].abs_y[0];
  assign dy[0].quo   = '0;

  // divide chain, one quotient bit per cell
  for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
    v2a_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv[j]),
      .item_i  (di[j]),
      .len_i   (dlen[j]),
      .lx_i    (dx[j]),
      .ly_i    (dy[j]),
      .valid_o (dv[j+1]),
      .item_o  (di[j+1]),
      .len_o   (dlen[j+1]),
      .lx_o    (dx[j+1]),
      .ly_o    (dy[j+1])
    );
  end

  assign fin = di[DIV_CELLS];
  assign len = dlen[DIV_CELLS];

  // select the result for the mode
  always_comb begin
    rx_d  = fin.rx;
    ry_d  = fin.ry;
    mag_d = '0;
    st_d  = fin.sat ? STAT_SAT : STAT_OK;
    unique case (fin.mode)
      MODE_ADD, MODE_SUB, MODE_SCALE: begin
      end
      MODE_LEN: begin
        rx_d  = '0;
        ry_d  = '0;
        mag_d = len;
        st_d  = STAT_OK;
      end
      MODE_NORM: begin
        if (len == '0) begin
          rx_d = '0;
          ry_d = '0;
          st_d = STAT_ZERO;
        end else begin
          rx_d = fin.neg_x ? -(WORD_BITS'(dx[DIV_CELLS].quo)) : WORD_BITS'(dx[DIV_CELLS].quo);
          ry_d = fin.neg_y ? -(WORD_BITS'(dy[DIV_CELLS].quo)) : WORD_BITS'(dy[DIV_CELLS].quo);
          st_d = STAT_OK;
        end
      end
      default: begin
        rx_d = '0;
        ry_d = '0;
        st_d = STAT_OK;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (en) begin
      ov_q <= dv[DIV_CELLS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rx_q  <= rx_d;
      ry_q  <= ry_d;
      mag_q <= mag_d;
      st_q  <= st_d;
    end
  end

  assign out_valid_o = ov_q;
  assign result_x_o  = rx_q;
  assign result_y_o  = ry_q;
  assign magnitude_o = mag_q;
  assign status_o    = st_q;

endmodule
`default_nettype wire

### src/v2a_checker.sv
// ----------------------------------------------------------------------------
// v2a_checker: port level checks for the 2D vector ALU
// Watches results on the top level ports and is bound to every instance.
// ----------------------------------------------------------------------------
`default_nettype none
module v2a_checker (
  input wire logic                                 clk_i,
  input wire logic                                 rst_ni,
  input wire logic                                 out_valid_o,
  input wire logic                                 out_stall_i,
  input wire logic signed [v2a_pkg::WORD_BITS-1:0] result_x_o,
  input wire logic signed [v2a_pkg::WORD_BITS-1:0] result_y_o,
  input wire logic [v2a_pkg::WORD_BITS-1:0]        magnitude_o,
  input wire logic [1:0]                           status_o
);
  import v2a_pkg::*;

  // a stalled item holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(result_x_o) &&
    $stable(result_y_o) && $stable(magnitude_o) && $stable(status_o))
    else $error("stalled item changed");

  // status code never out of range
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o != 2'd3)
    else $error("bad status");

  // zero vector normalize gives a zero item
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == STAT_ZERO |->
    result_x_o == '0 && result_y_o == '0 && magnitude_o == '0)
    else $error("zero normalize not zero");

  // a length never comes with a vector
  a_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && magnitude_o != '0 |->
    result_x_o == '0 && result_y_o == '0 && status_o == STAT_OK)
    else $error("length with vector");

endmodule

bind vector2d_alu_top v2a_checker u_v2a_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .result_x_o  (result_x_o),
  .result_y_o  (result_y_o),
  .magnitude_o (magnitude_o),
  .status_o    (status_o)
);
`default_nettype wire
